[design/lrss_pkg.sv]
// Shared types and constants of the LED ramp step sequencer.
package lrss_pkg;

  // Step table geometry
  localparam int STEP_COUNT = 10;
  localparam int StepW      = $clog2(STEP_COUNT + 1);
  localparam int IdxW       = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

  // Ramp arithmetic widths: numerator is signed, quotient is its magnitude
  localparam int NumW = 26;
  localparam int DivW = NumW - 1;
  localparam int CntW = $clog2(DivW);

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_UP   = 2'd2,
    MODE_DOWN = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CMD_CLOSE  = 2'd0,
    CMD_DRIVE  = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_BASE,
    ST_MUL_SLOPE,
    ST_SUM,
    ST_DIV,
    ST_FINAL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] offset;
    logic [15:0] duration;
    logic [7:0]  low;
    logic [7:0]  high;
  } step_t;

endpackage

[design/led_ramp_step_sequencer.sv]
// Top level of the LED ramp step sequencer: step table, sequencer, shared multiply/divide.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: action; tdata: restart..entry_high
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: command; tdata: level, current_out
//  cfg       in   cfg_we_i                      cfg_wdata_i: drive_current
//
// A table write is accepted in ST_IDLE. A tick that needs no ramp math goes from ST_EVAL
// to ST_EMIT, or back to ST_IDLE with no beat; a ramp tick runs ST_MUL_BASE and ST_MUL_SLOPE
// on the one shared 9x17 multiplier, then ST_SUM and the restoring divider that retires one
// quotient bit per cycle (25 bits); a negative sum skips the divide; ST_FINAL drops a level above high.
// Reset clears step pointer, elapsed time, table valid bits and drive_current; no sweep.
// A result waits in the output register; the next beat is accepted meanwhile and stalls
// only when its own result is ready and the output register is still full.
module led_ramp_step_sequencer
  import lrss_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] restart, [8:1] timebase, [12:9] entry_index, [14:13] entry_mode,
  // [30:15] entry_offset, [46:31] entry_duration, [54:47] entry_low,
  // [62:55] entry_high, [63] zero
  input  logic [63:0] s_axis_tdata,
  // [0] action
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] level, [23:8] current_out
  output logic [23:0] m_axis_tdata,
  // [1:0] command
  output logic [1:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  // Input field unpacking
  logic        in_restart;
  logic [7:0]  in_timebase;
  logic [3:0]  in_index;
  step_t       in_entry;

  assign in_restart        = s_axis_tdata[0];
  assign in_timebase       = s_axis_tdata[8:1];
  assign in_index          = s_axis_tdata[12:9];
  assign in_entry.mode     = mode_e'(s_axis_tdata[14:13]);
  assign in_entry.offset   = s_axis_tdata[30:15];
  assign in_entry.duration = s_axis_tdata[46:31];
  assign in_entry.low      = s_axis_tdata[54:47];
  assign in_entry.high     = s_axis_tdata[62:55];

  state_e state_q, state_d;

  logic              in_beat;
  logic              emit_load;
  logic [15:0]       drive_current_q;
  step_t             tbl_q [STEP_COUNT];
  logic [STEP_COUNT-1:0] tbl_vld_q;
  logic [StepW-1:0]  step_q;
  logic [15:0]       elapsed_q;
  logic [7:0]        timebase_q;

  // Latched ramp operands
  logic              up_q;
  logic [7:0]        low_q;
  logic [7:0]        high_q;
  logic [15:0]       span_q;
  logic [15:0]       t_q;
  logic [15:0]       cur_q;

  // Shared arithmetic
  logic signed [8:0]      mul_a;
  logic signed [16:0]     mul_b;
  logic signed [NumW-1:0] prod;
  logic signed [NumW-1:0] prod_q;
  logic signed [NumW-1:0] acc_q;
  logic signed [NumW-1:0] sum;
  logic [DivW-1:0]        quo_q;
  logic [15:0]            rem_q;
  logic [16:0]            rem_sh;
  logic                   rem_ge;
  logic [CntW-1:0]        cnt_q;

  // Pending result
  cmd_e        res_cmd_q;
  logic [7:0]  res_lvl_q;
  logic [15:0] res_cur_q;

  // Output register
  logic        m_valid_q;
  cmd_e        m_cmd_q;
  logic [7:0]  m_lvl_q;
  logic [15:0] m_cur_q;

  // Evaluation of the active step
  logic        ended;
  step_t       ent;
  logic [15:0] el_sum;
  logic        ge_off;
  logic        ge_dur;
  logic        span_pos;
  logic [7:0]  flat_lvl;
  logic signed [8:0] delta;
  logic        fin_keep;
  logic [7:0]  fin_lvl;

  typedef struct packed {
    state_e      go;
    cmd_e        cmd;
    logic [7:0]  lvl;
    logic [15:0] cur;
  } eval_t;
  eval_t ev;

  assign ended = step_q >= StepW'(STEP_COUNT);

  // Read the active entry; an unwritten entry reads as zero
  always_comb begin
    ent = '0;
    if (!ended && tbl_vld_q[step_q[IdxW-1:0]]) begin
      ent = tbl_q[step_q[IdxW-1:0]];
    end
  end

  assign el_sum   = elapsed_q + 16'(timebase_q);
  assign ge_off   = el_sum >= ent.offset;
  assign ge_dur   = el_sum >= ent.duration;
  assign span_pos = ent.duration > ent.offset;
  assign flat_lvl = (ent.mode == MODE_UP) ? ent.high : ent.low;
  assign delta    = $signed({1'b0, high_q}) - $signed({1'b0, low_q});

  // Decide what this tick sends and where the sequencer goes
  always_comb begin
    ev = '{go: ST_IDLE, cmd: CMD_CLOSE, lvl: 8'd0, cur: 16'd0};
    if (ended || ent.duration == 16'd0) begin
      ev.go  = ST_EMIT;
      ev.cmd = CMD_FINISH;
    end else if (ge_off) begin
      unique case (ent.mode)
        MODE_OFF: begin
          ev.go = ST_EMIT;
        end
        MODE_ON: begin
          ev.go  = ST_EMIT;
          ev.cmd = CMD_DRIVE;
          ev.lvl = (ent.high == 8'd0) ? 8'd1 : ent.high;
          ev.cur = drive_current_q;
        end
        MODE_UP, MODE_DOWN: begin
          if (span_pos) begin
            ev.go = ST_MUL_BASE;
          end else if (flat_lvl <= ent.high) begin
            ev.go  = ST_EMIT;
            ev.cmd = CMD_DRIVE;
            ev.lvl = (flat_lvl == 8'd0) ? 8'd1 : flat_lvl;
            ev.cur = drive_current_q;
          end
        end
        default: ev.go = ST_IDLE;
      endcase
    end else if (ent.mode == MODE_UP) begin
      ev.go  = ST_EMIT;
      ev.cmd = CMD_DRIVE;
    end
  end

  // Shared multiplier: base level times span, then slope times time
  always_comb begin
    mul_a = $signed({1'b0, up_q ? low_q : high_q});
    mul_b = $signed({1'b0, span_q});
    if (state_q == ST_MUL_SLOPE) begin
      mul_a = delta;
      mul_b = $signed({1'b0, t_q});
    end
  end
  assign prod = NumW'(mul_a) * NumW'(mul_b);
  assign sum  = up_q ? (acc_q + prod_q) : (acc_q - prod_q);

  // Restoring divide step
  assign rem_sh = {rem_q, quo_q[DivW-1]};
  assign rem_ge = rem_sh >= {1'b0, span_q};

  // Final level check after the divide
  assign fin_keep = quo_q <= DivW'(high_q);
  assign fin_lvl  = (quo_q[7:0] == 8'd0) ? 8'd1 : quo_q[7:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_beat && !s_axis_tuser[0]) state_d = ST_EVAL;
      ST_EVAL:      state_d = ev.go;
      ST_MUL_BASE:  state_d = ST_MUL_SLOPE;
      ST_MUL_SLOPE: state_d = ST_SUM;
      ST_SUM:       state_d = sum[NumW-1] ? ST_EMIT : ST_DIV;
      ST_DIV:       if (cnt_q == CntW'(DivW - 1)) state_d = ST_FINAL;
      ST_FINAL:     state_d = fin_keep ? ST_EMIT : ST_IDLE;
      ST_EMIT:      if (emit_load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // State machine outputs
  always_comb begin
    s_axis_tready = 1'b0;
    emit_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_EMIT: emit_load     = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      step_q          <= '0;
      elapsed_q       <= '0;
      drive_current_q <= '0;
      tbl_vld_q       <= '0;
      m_valid_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        drive_current_q <= cfg_wdata_i;
      end
      // Mark written entries
      if (in_beat && s_axis_tuser[0] && (32'(in_index) < STEP_COUNT)) begin
        tbl_vld_q[in_index[IdxW-1:0]] <= 1'b1;
      end
      // Restart on tick
      if (in_beat && !s_axis_tuser[0] && in_restart) begin
        step_q    <= '0;
        elapsed_q <= '0;
      end
      // Advance time and step
      if (state_q == ST_EVAL && !(ended || ent.duration == 16'd0)) begin
        if (ge_dur) begin
          elapsed_q <= '0;
          step_q    <= step_q + StepW'(1);
        end else begin
          elapsed_q <= el_sum;
        end
      end
      // Output beat handshake
      if (emit_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Step table storage
  always_ff @(posedge clk_i) begin
    if (in_beat && s_axis_tuser[0] && (32'(in_index) < STEP_COUNT)) begin
      tbl_q[in_index[IdxW-1:0]] <= in_entry;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      timebase_q <= in_timebase;
    end
    unique case (state_q)
      ST_EVAL: begin
        res_cmd_q <= ev.cmd;
        res_lvl_q <= ev.lvl;
        res_cur_q <= ev.cur;
        up_q      <= ent.mode == MODE_UP;
        low_q     <= ent.low;
        high_q    <= ent.high;
        span_q    <= ent.duration - ent.offset;
        t_q       <= el_sum - ent.offset;
        cur_q     <= drive_current_q;
      end
      ST_MUL_BASE:  acc_q  <= prod;
      ST_MUL_SLOPE: prod_q <= prod;
      ST_SUM: begin
        // Negative numerator saturates to zero, sent as one
        res_cmd_q <= CMD_DRIVE;
        res_lvl_q <= 8'd1;
        res_cur_q <= cur_q;
        quo_q     <= sum[DivW-1:0];
        rem_q     <= '0;
        cnt_q     <= '0;
      end
      ST_DIV: begin
        rem_q <= rem_ge ? 16'(rem_sh - {1'b0, span_q}) : rem_sh[15:0];
        quo_q <= {quo_q[DivW-2:0], rem_ge};
        cnt_q <= cnt_q + CntW'(1);
      end
      ST_FINAL: begin
        res_cmd_q <= CMD_DRIVE;
        res_lvl_q <= fin_lvl;
        res_cur_q <= cur_q;
      end
      default: ;
    endcase
    // Load the output register
    if (emit_load) begin
      m_cmd_q <= res_cmd_q;
      m_lvl_q <= res_lvl_q;
      m_cur_q <= res_cur_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_cmd_q;
  assign m_axis_tdata  = {m_cur_q, m_lvl_q};

`ifndef ASSERT_OFF
  // Step pointer never runs past the end marker
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= StepW'(STEP_COUNT))
    else $error("step pointer beyond end of table");

  // Finished and close beats carry no level and no current
  a_quiet_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == CMD_FINISH || m_axis_tuser == CMD_CLOSE)
    |-> m_axis_tdata == 24'd0)
    else $error("non-drive beat with payload");

  // A drive that carries current never has level zero
  a_drive_lvl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == CMD_DRIVE && m_axis_tdata[23:8] != 16'd0
    |-> m_axis_tdata[7:0] != 8'd0)
    else $error("drive beat with zero level");

  // The final check is entered only from the divider's last bit step
  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FINAL |-> $past(state_q) == ST_DIV && $past(cnt_q) == CntW'(DivW - 1))
    else $error("divider ended early");
`endif

endmodule
